/* sv/bnps_pkg.sv */
package bnps_pkg;

	localparam int unsigned BitmapBitsDefault = 1048576;
	localparam int unsigned AddrW = 32;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned ProbW = 16;
	localparam int unsigned WordW = 32;
	localparam int unsigned RamWordBits = 32;

	localparam logic [15:0] ProbReset = 16'd6554;
	localparam logic [31:0] SampleSeedReset = 32'd1232;
	localparam logic [31:0] PositionSeedReset = 32'd1545;

	localparam logic [CfgIdxW-1:0] RegProb = 2'd0;
	localparam logic [CfgIdxW-1:0] RegSampleSeed = 2'd1;
	localparam logic [CfgIdxW-1:0] RegPosSeed = 2'd2;

	localparam logic [31:0] C1 = 32'hcc9e2d51;
	localparam logic [31:0] C2 = 32'h1b873593;
	localparam logic [31:0] M1 = 32'h85ebca6b;
	localparam logic [31:0] M2 = 32'hc2b2ae35;
	localparam logic [31:0] MixAdd = 32'he6546b64;
	localparam logic [31:0] KeyLen = 32'd8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUB,
		ST_RED,
		ST_READ,
		ST_WRITE
	} back_state_t;

	function automatic logic [31:0] bswap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

endpackage

/* sv/bnps_pair_if.sv */
interface bnps_pair_if;
	logic valid;
	logic ready;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	modport source (output valid, source_address, destination_address, input ready);
	modport sink (input valid, source_address, destination_address, output ready);
endinterface

/* sv/bnps_result_if.sv */
interface bnps_result_if;
	logic valid;
	logic ready;
	logic pair_is_new;
	logic pair_sampled;
	logic [31:0] echo_source;
	logic [31:0] echo_destination;
	modport source (output valid, pair_is_new, pair_sampled, echo_source, echo_destination,
		input ready);
	modport sink (input valid, pair_is_new, pair_sampled, echo_source, echo_destination,
		output ready);
endinterface

/* sv/bnps_hash.sv */
// Front part: pipelined two-seed hash of the address pair.
module bnps_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  logic [31:0] src,
	input  logic [31:0] dst,
	input  logic [31:0] seed_a,
	input  logic [31:0] seed_b,
	output logic        out_valid,
	output logic [31:0] hash_a,
	output logic [31:0] hash_b,
	output logic [31:0] out_src,
	output logic [31:0] out_dst
);
	localparam int unsigned Stages = 10;

	logic [Stages-1:0] v_q;
	logic [31:0] src_q [Stages];
	logic [31:0] dst_q [Stages];
	logic [31:0] ha_q [Stages];
	logic [31:0] hb_q [Stages];
	logic [31:0] ka_q [Stages];
	logic [31:0] kb_q [Stages];

	// one step per stage, per hash lane
	function automatic void step(input int unsigned s, input logic [31:0] h,
		input logic [31:0] k, input logic [31:0] d, output logic [31:0] ho,
		output logic [31:0] ko);
		logic [31:0] t;
		ho = h;
		ko = k;
		unique case (s)
			0: ko = bnps_pkg::bswap32(k) * bnps_pkg::C1;
			1: ko = bnps_pkg::rotl(k, 15) * bnps_pkg::C2;
			2: begin
				t = bnps_pkg::rotl(h ^ k, 13);
				ho = t * 32'd5 + bnps_pkg::MixAdd;
				ko = bnps_pkg::bswap32(d) * bnps_pkg::C1;
			end
			3: ko = bnps_pkg::rotl(k, 15) * bnps_pkg::C2;
			4: begin
				t = bnps_pkg::rotl(h ^ k, 13);
				ho = t * 32'd5 + bnps_pkg::MixAdd;
			end
			5: begin
				t = ho ^ bnps_pkg::KeyLen;
				ho = t ^ (t >> 16);
			end
			6: ho = h * bnps_pkg::M1;
			7: ho = h ^ (h >> 13);
			8: ho = h * bnps_pkg::M2;
			default: ho = h ^ (h >> 16);
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[Stages-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] h0, k0, h1, k1;
		if (adv) begin
			step(0, seed_a, src, dst, h0, k0);
			step(0, seed_b, src, dst, h1, k1);
			ha_q[0] <= h0; ka_q[0] <= k0;
			hb_q[0] <= h1; kb_q[0] <= k1;
			src_q[0] <= src; dst_q[0] <= dst;
			for (int unsigned i = 1; i < Stages; i++) begin
				step(i, ha_q[i-1], ka_q[i-1], dst_q[i-1], h0, k0);
				step(i, hb_q[i-1], kb_q[i-1], dst_q[i-1], h1, k1);
				ha_q[i] <= h0; ka_q[i] <= k0;
				hb_q[i] <= h1; kb_q[i] <= k1;
				src_q[i] <= src_q[i-1]; dst_q[i] <= dst_q[i-1];
			end
		end
	end

	assign out_valid = v_q[Stages-1];
	assign hash_a = ha_q[Stages-1];
	assign hash_b = hb_q[Stages-1];
	assign out_src = src_q[Stages-1];
	assign out_dst = dst_q[Stages-1];
endmodule

/* sv/bnps_fifo.sv */
// Short queue between hash front and bitmap back.
module bnps_fifo #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             not_empty,
	output logic [$clog2(Depth+1)-1:0] count
);
	localparam int unsigned AW = $clog2(Depth);
	logic [Width-1:0] mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [$clog2(Depth+1)-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign not_empty = (cnt_q != '0);
	assign count = cnt_q;
endmodule

/* sv/bnps_back.sv */
// Back part: bitmap read-modify-write, set count and sampling test.
module bnps_back #(
	parameter int unsigned BitmapBits = bnps_pkg::BitmapBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  logic [31:0] q_hpos,
	input  logic [31:0] q_hsamp,
	input  logic [31:0] q_src,
	input  logic [31:0] q_dst,
	input  logic [15:0] prob,
	output logic        busy_clear,
	bnps_result_if.source res
);
	localparam int unsigned PosW = $clog2(BitmapBits);
	localparam int unsigned WordsRaw = (BitmapBits + 31) / 32;
	localparam int unsigned Words = (WordsRaw < 2) ? 2 : WordsRaw;
	localparam int unsigned WAW = $clog2(Words);
	localparam int unsigned CntW = PosW + 1;
	localparam logic [CntW-1:0] BitsC = CntW'(BitmapBits);
	localparam logic [31:0] BitsW = 32'(BitmapBits);
	// floor(2^32 / BitmapBits); the quotient estimate is low by at most one
	localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(BitmapBits));

	logic [31:0] ram_q [Words];
	logic [31:0] rd_q;
	bnps_pkg::back_state_t st_q, st_d;
	logic [WAW-1:0] clr_q;
	logic [CntW-1:0] cnt_q;
	logic [PosW-1:0] pos_q;
	logic [31:0] hs_q, src_q, dst_q;
	logic [31:0] hp_q, qe_q, prod_q, rem;
	logic [CntW-1:0] free_q;
	logic [63:0] lhs;
	logic [63:0] rhs;
	logic newb, obuf_free;

	// position hash modulo bitmap size: quotient estimate, product, one correction
	assign rem = hp_q - prod_q;
	assign obuf_free = !res.valid || res.ready;
	assign busy_clear = (st_q == bnps_pkg::ST_CLEAR);
	assign newb = !rd_q[pos_q[4:0]] && (cnt_q < BitsC);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			bnps_pkg::ST_CLEAR: if (clr_q == WAW'(Words - 1)) st_d = bnps_pkg::ST_IDLE;
			bnps_pkg::ST_IDLE: if (q_valid) st_d = bnps_pkg::ST_SUB;
			bnps_pkg::ST_SUB: st_d = bnps_pkg::ST_RED;
			bnps_pkg::ST_RED: st_d = bnps_pkg::ST_READ;
			bnps_pkg::ST_READ: st_d = bnps_pkg::ST_WRITE;
			bnps_pkg::ST_WRITE: if (obuf_free) st_d = bnps_pkg::ST_IDLE;
			default: st_d = bnps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (st_q == bnps_pkg::ST_IDLE) && q_valid;
	end

	assign lhs = 64'(hs_q) * 64'(free_q);
	assign rhs = (64'(prob) * 64'(BitmapBits)) << 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bnps_pkg::ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			res.valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == bnps_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == bnps_pkg::ST_WRITE && obuf_free) begin
				res.valid <= 1'b1;
				if (newb) cnt_q <= cnt_q + 1'b1;
			end else if (res.valid && res.ready) begin
				res.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == bnps_pkg::ST_CLEAR) ram_q[clr_q] <= '0;
		else if (st_q == bnps_pkg::ST_WRITE && obuf_free && newb)
			ram_q[WAW'(pos_q >> 5)] <= rd_q | (32'd1 << pos_q[4:0]);
		if (q_pop) begin
			hp_q <= q_hpos;
			qe_q <= 32'((64'(q_hpos) * 64'(Recip)) >> 32);
			hs_q <= q_hsamp;
			src_q <= q_src;
			dst_q <= q_dst;
		end
		if (st_q == bnps_pkg::ST_SUB) prod_q <= 32'(64'(qe_q) * 64'(BitsW));
		if (st_q == bnps_pkg::ST_RED)
			pos_q <= (rem >= BitsW) ? PosW'(rem - BitsW) : PosW'(rem);
		if (st_q == bnps_pkg::ST_READ) begin
			rd_q <= ram_q[WAW'(pos_q >> 5)];
			free_q <= BitsC - cnt_q;
		end
		if (st_q == bnps_pkg::ST_WRITE && obuf_free) begin
			res.pair_is_new <= newb;
			res.pair_sampled <= newb && (lhs < rhs);
			res.echo_source <= src_q;
			res.echo_destination <= dst_q;
		end
	end
endmodule

/* sv/bitmap_nonduplicate_pair_sampler.sv */
// Path: a pair passes the 10 hash stages and the queue, then the back part's steps
// in order (quotient, product, remainder, read, write to the output register).
// The back part takes a new pair from the queue only once it is through with the last,
// bound by its position reduction and single-port bitmap read-modify-write.
// Reset: asynchronous, active low; afterwards a clearing pass over the bitmap words
// zeroes the bitmap while no transaction is accepted.
module bitmap_nonduplicate_pair_sampler #(
	parameter int unsigned BITMAP_BITS = bnps_pkg::BitmapBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	bnps_pair_if.sink   pair,
	bnps_result_if.source result
);
	localparam int unsigned QDepth = 16;
	localparam int unsigned QW = 128;

	logic [15:0] prob_q;
	logic [31:0] sseed_q, pseed_q;
	logic adv, hv, pop, nempty, busy_clear;
	logic [31:0] ha, hb, hsrc, hdst;
	logic [QW-1:0] qd;
	logic [$clog2(QDepth+1)-1:0] qcnt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_q <= bnps_pkg::ProbReset;
			sseed_q <= bnps_pkg::SampleSeedReset;
			pseed_q <= bnps_pkg::PositionSeedReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bnps_pkg::RegProb: prob_q <= cfg_data[15:0];
				bnps_pkg::RegSampleSeed: sseed_q <= cfg_data;
				bnps_pkg::RegPosSeed: pseed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hash pipe moves only while the queue has room for everything in flight
	assign adv = (qcnt < ($clog2(QDepth+1))'(QDepth - 11));
	assign pair.ready = adv && !busy_clear;

	bnps_hash u_hash (
		.clk, .arst_n, .adv,
		.in_valid(pair.valid && pair.ready),
		.src(pair.source_address), .dst(pair.destination_address),
		.seed_a(pseed_q), .seed_b(sseed_q),
		.out_valid(hv), .hash_a(ha), .hash_b(hb), .out_src(hsrc), .out_dst(hdst)
	);

	bnps_fifo #(.Width(QW), .Depth(QDepth)) u_fifo (
		.clk, .arst_n,
		.push(hv && adv), .wdata({ha, hb, hsrc, hdst}),
		.pop, .rdata(qd), .not_empty(nempty), .count(qcnt)
	);

	bnps_back #(.BitmapBits(BITMAP_BITS)) u_back (
		.clk, .arst_n,
		.q_valid(nempty), .q_pop(pop),
		.q_hpos(qd[127:96]), .q_hsamp(qd[95:64]), .q_src(qd[63:32]), .q_dst(qd[31:0]),
		.prob(prob_q), .busy_clear, .res(result)
	);
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Predicts sampler results and checks them in arrival order
class pair_scoreboard;
	localparam int unsigned Bits = bnps_pkg::BitmapBitsDefault;
	bit pair_bitmap [];
	int unsigned set_count;
	logic [15:0] prob;
	logic [31:0] sample_seed;
	logic [31:0] pos_seed;
	logic [65:0] expected_results [$];
	int errors;

	function new();
		pair_bitmap = new[Bits];
		set_count = 0;
		prob = bnps_pkg::ProbReset;
		sample_seed = bnps_pkg::SampleSeedReset;
		pos_seed = bnps_pkg::PositionSeedReset;
		errors = 0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			bnps_pkg::RegProb: prob = val[15:0];
			bnps_pkg::RegSampleSeed: sample_seed = val;
			bnps_pkg::RegPosSeed: pos_seed = val;
			default: ;
		endcase
	endfunction

	function logic [31:0] rot(logic [31:0] x, int r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function logic [31:0] mix(logic [31:0] h, logic [31:0] k);
		k = k * 32'hcc9e2d51;
		k = rot(k, 15);
		k = k * 32'h1b873593;
		h = h ^ k;
		h = rot(h, 13);
		return h * 32'd5 + 32'he6546b64;
	endfunction

	function logic [31:0] murmur(logic [31:0] s, logic [31:0] d, logic [31:0] seed);
		logic [31:0] h;
		h = mix(seed, {s[7:0], s[15:8], s[23:16], s[31:24]});
		h = mix(h, {d[7:0], d[15:8], d[23:16], d[31:24]});
		h = h ^ 32'd8;
		h = h ^ (h >> 16);
		h = h * 32'h85ebca6b;
		h = h ^ (h >> 13);
		h = h * 32'hc2b2ae35;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// Accepted pair: update bitmap and queue the expected result
	function void note_pair(logic [31:0] s, logic [31:0] d);
		logic [31:0] hs, pos;
		logic [63:0] lhs, rhs;
		bit is_new, sampled;
		hs = murmur(s, d, sample_seed);
		pos = murmur(s, d, pos_seed) % Bits;
		is_new = 0;
		sampled = 0;
		if (!pair_bitmap[pos] && set_count < Bits) begin
			lhs = 64'(hs) * 64'(Bits - set_count);
			rhs = (64'(prob) * 64'(Bits)) << 16;
			sampled = lhs < rhs;
			is_new = 1;
			pair_bitmap[pos] = 1;
			set_count++;
		end
		expected_results.push_back({is_new, sampled, s, d});
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_result(logic n, logic sm, logic [31:0] s, logic [31:0] d);
		logic [65:0] e;
		if (expected_results.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		e = expected_results.pop_front();
		if (n !== e[65]) report($sformatf("pair_is_new %b exp %b", n, e[65]));
		if (sm !== e[64]) report($sformatf("pair_sampled %b exp %b", sm, e[64]));
		if (s !== e[63:32]) report($sformatf("echo_source %h exp %h", s, e[63:32]));
		if (d !== e[31:0]) report($sformatf("echo_destination %h exp %h", d, e[31:0]));
	endtask
endclass

module tb;
	localparam longint Limit = 64'd3000000;

	logic clk, arst_n, cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	int src_idle, dst_idle;
	longint cycles;
	pair_scoreboard sb;
	logic [31:0] seen_src [$];
	logic [31:0] seen_dst [$];

	bnps_pair_if pair ();
	bnps_result_if result ();

	bitmap_nonduplicate_pair_sampler uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pair(pair.sink), .result(result.source)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Timeout counter
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > Limit) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Sample transactions on rising edges
	always @(posedge clk) begin
		if (arst_n && pair.valid && pair.ready)
			sb.note_pair(pair.source_address, pair.destination_address);
		if (arst_n && result.valid && result.ready)
			sb.check_result(result.pair_is_new, result.pair_sampled,
				result.echo_source, result.echo_destination);
	end

	// Receiver stalls
	always @(negedge clk) begin
		result.ready <= ($urandom_range(99) >= dst_idle);
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_pair(logic [31:0] s, logic [31:0] d);
		while ($urandom_range(99) < src_idle) begin
			@(negedge clk);
			pair.valid <= 0;
		end
		@(negedge clk);
		pair.valid <= 1;
		pair.source_address <= s;
		pair.destination_address <= d;
		do @(posedge clk); while (!pair.ready);
		seen_src.push_back(s);
		seen_dst.push_back(d);
	endtask

	task automatic drain();
		@(negedge clk);
		pair.valid <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_pairs(int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(9);
			// Mostly fresh pairs, some repeats of earlier ones
			if (k < 3 && seen_src.size() > 0) begin
				k = $urandom_range(seen_src.size() - 1);
				send_pair(seen_src[k], seen_dst[k]);
			end else
				send_pair($urandom, $urandom);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		pair.valid = 0;
		pair.source_address = 0;
		pair.destination_address = 0;
		result.ready = 0;
		src_idle = 18;
		dst_idle = 82;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: field extremes, repeats, reset settings
		send_pair(32'h0, 32'h0);
		send_pair(32'hffffffff, 32'hffffffff);
		send_pair(32'h0, 32'hffffffff);
		send_pair(32'hffffffff, 32'h0);
		send_pair(32'h0, 32'h0);
		send_pair(32'h80000001, 32'h7ffffffe);
		send_pair(32'h80000001, 32'h7ffffffe);
		for (int i = 0; i < 8; i++) send_pair(32'h1 << (4 * i), 32'h80000000 >> (4 * i));
		drain();

		// Zero probability, out-of-range index ignored
		cfg_write(bnps_pkg::RegProb, 32'h0);
		cfg_write(2'd3, 32'hdeadbeef);
		for (int i = 0; i < 5; i++) send_pair($urandom, $urandom);
		send_pair(32'h0, 32'h0);
		drain();

		// Maximum probability, wide value truncated, extreme seeds
		cfg_write(bnps_pkg::RegProb, 32'hffffffff);
		cfg_write(bnps_pkg::RegSampleSeed, 32'hffffffff);
		cfg_write(bnps_pkg::RegPosSeed, 32'h0);
		random_pairs(5);
		drain();

		cfg_write(bnps_pkg::RegProb, $urandom_range(65535));
		cfg_write(bnps_pkg::RegSampleSeed, $urandom);
		cfg_write(bnps_pkg::RegPosSeed, $urandom);
		random_pairs(430);
		drain();

		src_idle = 82;
		dst_idle = 18;
		cfg_write(bnps_pkg::RegProb, 32'h8000);
		cfg_write(bnps_pkg::RegSampleSeed, 32'h0);
		cfg_write(bnps_pkg::RegPosSeed, 32'hffffffff);
		random_pairs(430);
		drain();

		src_idle = 0;
		dst_idle = 0;
		cfg_write(bnps_pkg::RegProb, bnps_pkg::ProbReset);
		cfg_write(bnps_pkg::RegSampleSeed, bnps_pkg::SampleSeedReset);
		cfg_write(bnps_pkg::RegPosSeed, bnps_pkg::PositionSeedReset);
		random_pairs(430);
		drain();

		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
